// ----- rtl/core/bfa_pkg.sv -----
// bfa_pkg: shared types and constants for the buddy frame allocator.
// Used by bfa_ctrl, bfa_dpath and buddy_frame_allocator_core.
package bfa_pkg;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_SCAN,
    ST_A_RD,
    ST_A_UNL,
    ST_A_UNL2,
    ST_A_SPLIT,
    ST_A_FIN,
    ST_F_RD,
    ST_F_CHK,
    ST_F_BRD,
    ST_F_BCHK,
    ST_F_UNL,
    ST_F_UNL2,
    ST_F_PUSH,
    ST_F_PUSH2,
    ST_FAIL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic init_step;
    logic load_req;
    logic scan_step;
    logic rd_head;
    logic unl_a;
    logic unl_b;
    logic split_a;
    logic alloc_fin;
    logic rd_self;
    logic rd_buddy;
    logic merge_step;
    logic push_a;
    logic push_b;
    logic set_fail;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic is_free;
    logic order_bad;
    logic scan_hit;
    logic scan_end;
    logic split_done;
    logic self_bad;
    logic can_merge;
    logic merge_top;
  } stat_t;

endpackage

// ----- rtl/core/bfa_ctrl.sv -----
// bfa_ctrl: request sequencer of the buddy frame allocator.
// Depends on bfa_pkg; drives bfa_dpath through cmd_t, reads stat_t.
module bfa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            action,
  input  logic            out_stall,
  input  bfa_pkg::stat_t  st,
  output bfa_pkg::cmd_t   cmd,
  output logic            in_stall,
  output logic            out_valid
);

  bfa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bfa_pkg::ST_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bfa_pkg::ST_INIT:    if (st.init_done) state_next = bfa_pkg::ST_IDLE;
      bfa_pkg::ST_IDLE: begin
        if (in_valid) state_next = action ? bfa_pkg::ST_F_RD : bfa_pkg::ST_A_SCAN;
      end
      bfa_pkg::ST_A_SCAN: begin
        if (st.order_bad)     state_next = bfa_pkg::ST_FAIL;
        else if (st.scan_hit) state_next = bfa_pkg::ST_A_RD;
        else if (st.scan_end) state_next = bfa_pkg::ST_FAIL;
      end
      bfa_pkg::ST_A_RD:    state_next = bfa_pkg::ST_A_UNL;
      bfa_pkg::ST_A_UNL:   state_next = bfa_pkg::ST_A_UNL2;
      bfa_pkg::ST_A_UNL2:  state_next = bfa_pkg::ST_A_SPLIT;
      bfa_pkg::ST_A_SPLIT: if (st.split_done) state_next = bfa_pkg::ST_A_FIN;
      bfa_pkg::ST_A_FIN:   state_next = bfa_pkg::ST_OUT;
      bfa_pkg::ST_F_RD:    state_next = bfa_pkg::ST_F_CHK;
      bfa_pkg::ST_F_CHK:   state_next = st.self_bad ? bfa_pkg::ST_FAIL : bfa_pkg::ST_F_BRD;
      bfa_pkg::ST_F_BRD: begin
        state_next = st.merge_top ? bfa_pkg::ST_F_PUSH : bfa_pkg::ST_F_BCHK;
      end
      bfa_pkg::ST_F_BCHK: begin
        state_next = st.can_merge ? bfa_pkg::ST_F_UNL : bfa_pkg::ST_F_PUSH;
      end
      bfa_pkg::ST_F_UNL:   state_next = bfa_pkg::ST_F_UNL2;
      bfa_pkg::ST_F_UNL2:  state_next = bfa_pkg::ST_F_BRD;
      bfa_pkg::ST_F_PUSH:  state_next = bfa_pkg::ST_F_PUSH2;
      bfa_pkg::ST_F_PUSH2: state_next = bfa_pkg::ST_OUT;
      bfa_pkg::ST_FAIL:    state_next = bfa_pkg::ST_OUT;
      bfa_pkg::ST_OUT:     if (!out_stall) state_next = bfa_pkg::ST_IDLE;
      default:             state_next = bfa_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      bfa_pkg::ST_INIT:    cmd.init_step = 1'b1;
      bfa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load_req = in_valid;
      end
      bfa_pkg::ST_A_SCAN:  cmd.scan_step = 1'b1;
      bfa_pkg::ST_A_RD:    cmd.rd_head = 1'b1;
      bfa_pkg::ST_A_UNL:   cmd.unl_a = 1'b1;
      bfa_pkg::ST_A_UNL2:  cmd.unl_b = 1'b1;
      bfa_pkg::ST_A_SPLIT: cmd.split_a = 1'b1;
      bfa_pkg::ST_A_FIN:   cmd.alloc_fin = 1'b1;
      bfa_pkg::ST_F_RD:    cmd.rd_self = 1'b1;
      bfa_pkg::ST_F_CHK:   cmd.set_fail = st.self_bad;
      bfa_pkg::ST_F_BRD:   cmd.rd_buddy = 1'b1;
      bfa_pkg::ST_F_BCHK:  ;
      bfa_pkg::ST_F_UNL:   cmd.unl_a = 1'b1;
      bfa_pkg::ST_F_UNL2: begin
        cmd.unl_b = 1'b1;
        cmd.merge_step = 1'b1;
      end
      bfa_pkg::ST_F_PUSH:  cmd.push_a = 1'b1;
      bfa_pkg::ST_F_PUSH2: cmd.push_b = 1'b1;
      bfa_pkg::ST_FAIL:    cmd.set_fail = 1'b1;
      bfa_pkg::ST_OUT:     out_valid = 1'b1;
      default:             ;
    endcase
  end

endmodule

// ----- rtl/core/bfa_dpath.sv -----
// bfa_dpath: frame tables, free list heads and result registers.
// Depends on bfa_pkg; commanded by bfa_ctrl.
module bfa_dpath #(
  parameter int FRAME_COUNT     = 1024,
  parameter int MAX_BLOCK_ORDER = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  bfa_pkg::cmd_t  cmd,
  input  logic [11:0]    request_frames,
  input  logic [9:0]     frame_index,
  output bfa_pkg::stat_t st,
  output logic           ok,
  output logic [9:0]     block_index,
  output logic [3:0]     block_order
);

  localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int LW = $clog2(FRAME_COUNT + 1);
  localparam int OW = $clog2(MAX_BLOCK_ORDER + 2);
  localparam int NL = MAX_BLOCK_ORDER + 1;
  localparam logic [LW-1:0] NO_LINK = LW'(FRAME_COUNT);
  localparam logic [OW-1:0] MAXO = OW'(MAX_BLOCK_ORDER);
  localparam logic [OW:0] NOT_START = '1;

  // per-frame memories: order (with not-start code), free, next, prev
  logic [OW:0]   ord_mem  [FRAME_COUNT];
  logic          free_mem [FRAME_COUNT];
  logic [LW-1:0] next_mem [FRAME_COUNT];
  logic [LW-1:0] prev_mem [FRAME_COUNT];
  logic [LW-1:0] head [NL];

  logic [LW:0]   init_pos;
  logic [LW:0]   blk_pos;  // next block start of the reset carve
  logic [OW-1:0] init_k;
  logic [OW:0]   ord;      // requested / current order
  logic [OW:0]   k;        // scan order
  logic [IW-1:0] idx;
  logic [IW-1:0] tgt;      // block being unlinked
  logic [OW-1:0] tgt_ord;
  logic [LW-1:0] rd_next, rd_prev;
  logic [OW:0]   rd_ord;
  logic          rd_free;
  logic [LW-1:0] bud;

  // rounded order of the request
  logic [OW+1:0] req_ord;
  always_comb begin
    req_ord = '0;
    for (int i = 0; i < 13; i++)
      if ((13'(1) << i) < {1'b0, request_frames}) req_ord = (OW + 2)'(i + 1);
  end

  // reset carve: largest aligned block at init_pos that fits
  always_comb begin
    init_k = '0;
    for (int j = 1; j <= MAX_BLOCK_ORDER; j++)
      if ((init_pos & ((LW + 1)'(1) << j) - 1'b1) == '0 &&
          init_pos + ((LW + 1)'(1) << j) <= (LW + 1)'(FRAME_COUNT))
        init_k = OW'(j);
  end

  assign st.init_done  = init_pos >= (LW + 1)'(FRAME_COUNT);
  assign st.order_bad  = ord > {1'b0, MAXO};
  assign st.scan_hit   = head[k[OW-1:0]] != NO_LINK;
  assign st.scan_end   = k >= {1'b0, MAXO};
  assign st.split_done = k == ord;
  assign st.is_free    = rd_free;
  assign st.self_bad   = rd_ord > {1'b0, MAXO} || rd_free;
  assign st.merge_top  = ord >= {1'b0, MAXO} ||
                         ({1'b0, idx ^ IW'(1 << ord[OW-1:0])} >= (IW + 1)'(FRAME_COUNT));
  assign st.can_merge  = rd_free && rd_ord == ord;
  assign bud = LW'(idx ^ IW'(1 << ord[OW-1:0]));

  logic [IW-1:0] sidx;
  logic [OW-1:0] sord;
  assign sord = OW'(k - 1'b1);
  assign sidx = idx ^ IW'(1 << sord);

  always_ff @(posedge clk) begin
    if (rst) begin
      init_pos <= '0;
      blk_pos  <= '0;
      for (int h = 0; h < NL; h++) head[h] <= NO_LINK;
    end else begin
      if (cmd.init_step && !st.init_done) begin
        free_mem[init_pos[IW-1:0]] <= 1'b1;
        if (init_pos == blk_pos) begin
          ord_mem[init_pos[IW-1:0]]  <= {1'b0, init_k};
          next_mem[init_pos[IW-1:0]] <= head[init_k];
          prev_mem[init_pos[IW-1:0]] <= NO_LINK;
          if (head[init_k] != NO_LINK) prev_mem[head[init_k][IW-1:0]] <= LW'(init_pos);
          head[init_k] <= LW'(init_pos);
          blk_pos <= blk_pos + ((LW + 1)'(1) << init_k);
        end else begin
          ord_mem[init_pos[IW-1:0]] <= NOT_START;
        end
        init_pos <= init_pos + 1'b1;
      end
      if (cmd.load_req) begin
        ok  <= 1'b1;
        ord <= req_ord[OW:0] > (OW + 1)'(MAX_BLOCK_ORDER + 1) ? '1 : req_ord[OW:0];
        k   <= req_ord[OW:0];
        idx <= IW'(frame_index);
      end
      if (cmd.scan_step && !st.scan_hit) k <= k + 1'b1;
      if (cmd.rd_head) begin
        idx     <= head[k[OW-1:0]][IW-1:0];
        tgt     <= head[k[OW-1:0]][IW-1:0];
        tgt_ord <= k[OW-1:0];
      end
      if (cmd.rd_buddy) begin
        tgt     <= bud[IW-1:0];
        tgt_ord <= ord[OW-1:0];
      end
      if (cmd.rd_self || cmd.rd_buddy) begin
        rd_ord  <= ord_mem[cmd.rd_self ? idx : bud[IW-1:0]];
        rd_free <= free_mem[cmd.rd_self ? idx : bud[IW-1:0]];
      end
      if (cmd.rd_self) ord <= ord_mem[idx];
      if (cmd.unl_a) begin
        rd_prev <= prev_mem[tgt];
        rd_next <= next_mem[tgt];
        ord_mem[tgt] <= NOT_START;
      end
      if (cmd.unl_b) begin
        if (rd_prev != NO_LINK) next_mem[rd_prev[IW-1:0]] <= rd_next;
        else head[tgt_ord] <= rd_next;
        if (rd_next != NO_LINK) prev_mem[rd_next[IW-1:0]] <= rd_prev;
      end
      if (cmd.merge_step) begin
        if (tgt < idx) begin
          ord_mem[idx] <= NOT_START;
          idx <= tgt;
        end
        ord <= ord + 1'b1;
      end
      if (cmd.split_a && !st.split_done) begin
        ord_mem[sidx]  <= {1'b0, sord};
        free_mem[sidx] <= 1'b1;
        next_mem[sidx] <= head[sord];
        prev_mem[sidx] <= NO_LINK;
        if (head[sord] != NO_LINK) prev_mem[head[sord][IW-1:0]] <= LW'(sidx);
        head[sord] <= LW'(sidx);
        k <= k - 1'b1;
      end
      if (cmd.alloc_fin) begin
        free_mem[idx] <= 1'b0;
        ord_mem[idx]  <= ord;
      end
      if (cmd.push_a) begin
        rd_next <= head[ord[OW-1:0]];
        next_mem[idx] <= head[ord[OW-1:0]];
        prev_mem[idx] <= NO_LINK;
        ord_mem[idx]  <= ord;
        free_mem[idx] <= 1'b1;
        head[ord[OW-1:0]] <= LW'(idx);
      end
      if (cmd.push_b && rd_next != NO_LINK) prev_mem[rd_next[IW-1:0]] <= LW'(idx);
      if (cmd.set_fail) begin
        ok <= 1'b0;
        idx <= '0;
        ord <= '0;
      end
    end
  end

  assign block_index = 10'(idx);
  assign block_order = 4'(ord);

endmodule

// ----- rtl/core/buddy_frame_allocator_core.sv -----
// buddy_frame_allocator_core: top level of the buddy frame allocator.
// Depends on bfa_pkg, bfa_ctrl and bfa_dpath.
//
//  channel | signals                                   | dir
//  in      | in_valid in_stall action request_frames frame_index | request in
//  out     | out_valid out_stall ok block_index block_order      | result out
//
// Allocate scans the orders upward, unlinks the head block and splits it down to the request.
// Oversize allocate fails on its order check; empty lists fail once the scan reaches MAX_BLOCK_ORDER.
// Free reads and checks the block, then per merge level reads, checks and unlinks the buddy,
// then pushes the merged block; a bad free fails after its self check.
// After reset a pass of one frame a cycle carves the pool
// before the first request is taken.
// A stalled result holds the block; no new request is taken until it leaves.
module buddy_frame_allocator_core #(
  parameter int FRAME_COUNT     = 1024,
  parameter int MAX_BLOCK_ORDER = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [11:0] request_frames,
  input  logic [9:0]  frame_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [9:0]  block_index,
  output logic [3:0]  block_order
);

  bfa_pkg::cmd_t  cmd;
  bfa_pkg::stat_t st;

  bfa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .action, .out_stall, .st, .cmd, .in_stall, .out_valid
  );

  bfa_dpath #(.FRAME_COUNT(FRAME_COUNT), .MAX_BLOCK_ORDER(MAX_BLOCK_ORDER)) u_dpath (
    .clk, .rst, .cmd, .request_frames, .frame_index, .st, .ok, .block_index, .block_order
  );

  a_excl: assert property (@(posedge clk) disable iff (rst) !(out_valid && !in_stall))
    else $error("request taken while result pending");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> block_index == 10'd0 && block_order == 4'd0)
    else $error("failure result not cleared");
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> block_order <= 4'(MAX_BLOCK_ORDER))
    else $error("order out of range");

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for buddy_frame_allocator_core.
// Holds its own buddy allocator model and a scoreboard class for the results.
// Depends on the RTL top level only.
`timescale 1ns / 1ps

class alloc_scoreboard;
  bit [14:0] pending[$];
  int errors;
  int checked;
  int ok_count;

  function void note_request(bit okv, bit [9:0] idx, bit [3:0] ord);
    pending.push_back({okv, idx, ord});
  endfunction

  function void check_result(bit okv, bit [9:0] idx, bit [3:0] ord);
    bit [14:0] exp_res;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result ok=%0d idx=%0d ord=%0d", okv, idx, ord);
      return;
    end
    exp_res = pending.pop_front();
    checked++;
    if (okv) ok_count++;
    if (exp_res != {okv, idx, ord}) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected ok=%0d idx=%0d ord=%0d, got ok=%0d idx=%0d ord=%0d",
                 exp_res[14], exp_res[13:4], exp_res[3:0], okv, idx, ord);
    end
  endfunction
endclass

module tb_top;
  localparam int NFRAMES  = 1024;
  localparam int TOP_ORD  = 10;
  localparam int NONE     = NFRAMES;
  localparam int NOTSTART = 15;
  localparam bit OP_ALLOC = 1'b0;
  localparam bit OP_FREE  = 1'b1;
  localparam int WDOG_LIMIT = 20000;

  logic clk, rst;
  logic in_valid, in_stall, action;
  logic [11:0] request_frames;
  logic [9:0] frame_index;
  logic out_valid, out_stall, ok;
  logic [9:0] block_index;
  logic [3:0] block_order;

  buddy_frame_allocator_core dut (.*);

  int blk_ord[NFRAMES];
  bit blk_free[NFRAMES];
  int nxt[NFRAMES];
  int prv[NFRAMES];
  int head[TOP_ORD + 1];
  int live[$];
  alloc_scoreboard sb;
  int idle_cycles;
  int n_alloc, n_free;

  function void push_free(int idx, int ord);
    nxt[idx] = head[ord];
    prv[idx] = NONE;
    if (head[ord] < NONE) prv[head[ord]] = idx;
    head[ord] = idx;
    blk_ord[idx] = ord;
    blk_free[idx] = 1;
  endfunction

  function void unlink_free(int idx, int ord);
    if (prv[idx] < NONE) nxt[prv[idx]] = nxt[idx];
    else head[ord] = nxt[idx];
    if (nxt[idx] < NONE) prv[nxt[idx]] = prv[idx];
    blk_ord[idx] = NOTSTART;
  endfunction

  function void pool_reset();
    int i, k;
    for (i = 0; i < NFRAMES; i++) begin
      blk_ord[i] = NOTSTART; blk_free[i] = 1; nxt[i] = NONE; prv[i] = NONE;
    end
    for (k = 0; k <= TOP_ORD; k++) head[k] = NONE;
    i = 0;
    while (i < NFRAMES) begin
      k = TOP_ORD;
      while (k > 0 && ((i % (1 << k)) != 0 || i + (1 << k) > NFRAMES)) k--;
      push_free(i, k);
      i += 1 << k;
    end
  endfunction

  function void predict_alloc(int req);
    int ord, k, idx;
    ord = 0;
    while (ord < 13 && (1 << ord) < req) ord++;
    if (ord > TOP_ORD) begin sb.note_request(0, 0, 0); return; end
    k = ord;
    while (k <= TOP_ORD && head[k] >= NONE) k++;
    if (k > TOP_ORD) begin sb.note_request(0, 0, 0); return; end
    idx = head[k];
    unlink_free(idx, k);
    while (k > ord) begin
      k--;
      push_free(idx ^ (1 << k), k);
    end
    blk_free[idx] = 0;
    blk_ord[idx] = ord;
    live.push_back(idx);
    sb.note_request(1, idx[9:0], ord[3:0]);
  endfunction

  function void predict_free(int idx);
    int ord, b;
    if (blk_ord[idx] > TOP_ORD || blk_free[idx]) begin
      sb.note_request(0, 0, 0); return;
    end
    ord = blk_ord[idx];
    while (ord < TOP_ORD) begin
      b = idx ^ (1 << ord);
      if (b >= NFRAMES || !blk_free[b] || blk_ord[b] != ord) break;
      unlink_free(b, ord);
      if (b < idx) begin blk_ord[idx] = NOTSTART; idx = b; end
      ord++;
    end
    push_free(idx, ord);
    sb.note_request(1, idx[9:0], ord[3:0]);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic send(bit act, int req, int fidx);
    @(negedge clk);
    in_valid <= 1; action <= act; request_frames <= req[11:0]; frame_index <= fidx[9:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == OP_ALLOC) begin predict_alloc(req); n_alloc++; end
    else begin predict_free(fidx); n_free++; end
    if ($urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_free_live();
    int p, f;
    p = $urandom_range(0, live.size() - 1);
    f = live[p];
    live.delete(p);
    send(OP_FREE, 0, f);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(ok, block_index, block_order);
  end

  int stall_mode;
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int i, r, burst;
    sb = new();
    rst = 1; in_valid = 0; action = 0; request_frames = 0; frame_index = 0;
    pool_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: edge sizes, oversize, invalid frees, full exhaustion and merge back
    send(OP_ALLOC, 0, 1023);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 3, 0);
    send(OP_ALLOC, 1025, 0);
    send(OP_ALLOC, 4095, 0);
    send(OP_FREE, 0, 1023);
    send(OP_FREE, 0, 5);
    send(OP_ALLOC, 1024, 0);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 512, 0);
    send(OP_ALLOC, 256, 0);
    send(OP_ALLOC, 256, 0);
    send(OP_ALLOC, 2048, 0);
    while (live.size() > 0) send_free_live();
    send(OP_FREE, 0, 0);
    send(OP_ALLOC, 1024, 0);
    send(OP_ALLOC, 1, 0);
    while (live.size() > 0) send_free_live();
    drain();
    for (i = 0; i < 500; ) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 50) send(OP_ALLOC, (r < 40) ? $urandom_range(0, 64) : $urandom_range(0, 4095), 0);
        else if (r < 90 && live.size() > 0) send_free_live();
        else send(OP_FREE, 0, $urandom_range(0, 1023));
        i++;
      end
      if ($urandom_range(0, 9) == 0) drain();
      else begin
        @(negedge clk);
        in_valid <= 0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
    drain();
    $display("covered %0d allocate and %0d free requests, %0d results checked, %0d succeeded",
             n_alloc, n_free, sb.checked, sb.ok_count);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
